// ----- src/piecewise_linear_speed_map_assert.svh -----
// Assertion macros for the piecewise-linear speed map.
// Included by the top level; needs nothing else.
`ifndef PIECEWISE_LINEAR_SPEED_MAP_ASSERT_SVH
`define PIECEWISE_LINEAR_SPEED_MAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PLSM_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Plain invariant, disabled while reset is high.
`define PLSM_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// ----- src/plsm_pkg.sv -----
// Shared types and constants for the piecewise-linear speed map.
// No dependencies; imported by every module of the block.
package plsm_pkg;

   localparam int SPEED_W       = 16;
   localparam int NUM_BP        = 4;
   localparam int SEG_W         = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int NUM_CSR       = 2 * NUM_BP;
   localparam int QUO_W         = SPEED_W;
   localparam int PROD_W        = 2 * SPEED_W;
   localparam int BITS_PER_STEP = 2;
   localparam int DIV_STEPS     = QUO_W / BITS_PER_STEP;
   localparam int SUM_W         = SPEED_W + 2;
   localparam int RSP_DATA_W    = 24;

   localparam logic [SEG_W-1:0] SEG_TOP = 3'd4;

   typedef enum logic {
      OP_ABS_TO_REL = 1'b0,
      OP_REL_TO_ABS = 1'b1
   } op_type;

   typedef logic [SPEED_W-1:0] bp_type;
   typedef bp_type [NUM_BP-1:0] curve_type;

   // fields that ride alongside the divider
   typedef struct packed {
      logic               neg;
      logic [SEG_W-1:0]   seg;
      logic               zero_span;
      logic               dy_neg;
      logic [SPEED_W-1:0] y1;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic [SPEED_W-1:0] dy_mag;
      logic [SPEED_W-1:0] dx;
      logic [SPEED_W-1:0] span;
   } interp_type;

   typedef struct packed {
      side_type         side;
      logic [QUO_W-1:0] quo;
   } quot_type;

endpackage

// ----- src/piecewise_linear_speed_map.sv -----
// Piecewise-linear speed map, 14-stage pipeline.
// Throughput: one beat per cycle unless the output stalls; the 8-stage divider (2 quotient bits each)
// sets the depth. The input stalls only when every stage holds a beat; bubbles are absorbed.
// Reset (synchronous): clears all valid bits and all eight breakpoint registers.
`include "piecewise_linear_speed_map_assert.svh"

module piecewise_linear_speed_map (
   input  logic                             clock,
   input  logic                             reset,
   // slave side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [plsm_pkg::SPEED_W-1:0]     req_tdata,  // [15:0] speed_in
   input  logic [0:0]                       req_tuser,  // [0] operation
   // master side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [plsm_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [15:0] speed_out, [18:16] segment
   // breakpoint registers
   input  logic                             csr_we,
   input  logic [plsm_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [plsm_pkg::SPEED_W-1:0]     csr_wdata
);
   import plsm_pkg::*;

   bp_type             cfg_ff [NUM_CSR];
   curve_type          abs_curve, rel_curve;

   logic               f_valid, f_ready;
   interp_type         f_data;
   logic               d_valid, d_ready;
   quot_type           d_data;
   logic [SPEED_W-1:0] speed_out;
   logic [SEG_W-1:0]   segment;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_addr] <= csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_BP; k++) begin
         abs_curve[k] = cfg_ff[k];
         rel_curve[k] = cfg_ff[NUM_BP + k];
      end
   end

   plsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (op_type'(req_tuser[0])),
      .in_speed  (req_tdata),
      .abs_curve (abs_curve),
      .rel_curve (rel_curve),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   plsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   plsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_data   (d_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_speed (speed_out),
      .out_seg   (segment)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SPEED_W - SEG_W){1'b0}}, segment, speed_out};

   // the pipeline only backs up when a finished beat is held at the output
   `PLSM_ASSERT_IMPL(a_stall_from_output, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready, "input stalled without output back-pressure")

   `PLSM_ASSERT_IMPL(a_segment_range, clock, reset, rsp_tvalid,
      segment <= SEG_TOP, "segment code out of range")

   // beyond the top breakpoint the result carries no sign
   `PLSM_ASSERT_ALWAYS(a_top_positive, clock, reset,
      !(rsp_tvalid && (segment == SEG_TOP) && speed_out[SPEED_W-1]),
      "negative result beyond top breakpoint")

   // the front end hands on only segment codes 0 to 4
   `PLSM_ASSERT_IMPL(a_front_seg_range, clock, reset, f_valid,
      f_data.side.seg <= SEG_TOP, "front end produced bad segment")

endmodule

// ----- src/plsm_front.sv -----
// Front end: magnitude, segment search and interpolation deltas (3 stages).
// Depends on plsm_pkg.
module plsm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  plsm_pkg::op_type      in_op,
   input  logic [plsm_pkg::SPEED_W-1:0] in_speed,
   input  plsm_pkg::curve_type   abs_curve,
   input  plsm_pkg::curve_type   rel_curve,
   output logic                  out_valid,
   input  logic                  out_ready,
   output plsm_pkg::interp_type  out_data
);
   import plsm_pkg::*;

   logic               a_en, b_en, c_en;

   logic               a_v_ff;
   op_type             a_op_ff;
   logic               a_neg_ff;
   logic [SPEED_W-1:0] a_mag_ff;
   logic [SPEED_W-1:0] a_mag_in;

   logic               b_v_ff;
   logic               b_neg_ff, b_neg_in;
   logic [SEG_W-1:0]   b_seg_ff, b_seg_in;
   logic [SPEED_W-1:0] b_mag_ff;
   bp_type             b_x1_ff, b_x1_in, b_x2_ff, b_x2_in;
   bp_type             b_y1_ff, b_y1_in, b_y2_ff, b_y2_in;

   logic               c_v_ff;
   interp_type         c_ff, c_in;

   assign c_en     = !c_v_ff || out_ready;
   assign b_en     = !b_v_ff || c_en;
   assign a_en     = !a_v_ff || b_en;
   assign in_ready = a_en;

   // -32768 maps to 16'h8000, read as unsigned 32768
   assign a_mag_in = in_speed[SPEED_W-1] ? (~in_speed + 1'b1) : in_speed;

   always_comb begin : seg_sel
      curve_type xs;
      curve_type ys;
      bp_type    xlo [NUM_BP];
      bp_type    ylo [NUM_BP];
      xs     = (a_op_ff == OP_REL_TO_ABS) ? rel_curve : abs_curve;
      ys     = (a_op_ff == OP_REL_TO_ABS) ? abs_curve : rel_curve;
      xlo[0] = '0;
      ylo[0] = '0;
      for (int k = 1; k < NUM_BP; k++) begin
         xlo[k] = xs[k-1];
         ylo[k] = ys[k-1];
      end
      // beyond the top: zero span, positive top output
      b_seg_in = SEG_TOP;
      b_x1_in  = '0;
      b_x2_in  = '0;
      b_y1_in  = ys[NUM_BP-1];
      b_y2_in  = ys[NUM_BP-1];
      // walk down so the lowest matching breakpoint wins
      for (int k = NUM_BP - 1; k >= 0; k--) begin
         if (a_mag_ff <= xs[k]) begin
            b_seg_in = SEG_W'(k);
            b_x1_in  = xlo[k];
            b_x2_in  = xs[k];
            b_y1_in  = ylo[k];
            b_y2_in  = ys[k];
         end
      end
      b_neg_in = a_neg_ff && (b_seg_in != SEG_TOP);
   end

   always_comb begin
      c_in.side.neg       = b_neg_ff;
      c_in.side.seg       = b_seg_ff;
      c_in.side.zero_span = (b_x2_ff == b_x1_ff);
      c_in.side.dy_neg    = (b_y2_ff < b_y1_ff);
      c_in.side.y1        = b_y1_ff;
      c_in.dy_mag         = (b_y2_ff < b_y1_ff) ? (b_y1_ff - b_y2_ff) : (b_y2_ff - b_y1_ff);
      c_in.dx             = b_mag_ff - b_x1_ff;
      c_in.span           = b_x2_ff - b_x1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_v_ff <= in_valid;
         end
         if (b_en) begin
            b_v_ff <= a_v_ff;
         end
         if (c_en) begin
            c_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_op_ff  <= in_op;
         a_neg_ff <= in_speed[SPEED_W-1];
         a_mag_ff <= a_mag_in;
      end
      if (b_en) begin
         b_neg_ff <= b_neg_in;
         b_seg_ff <= b_seg_in;
         b_mag_ff <= a_mag_ff;
         b_x1_ff  <= b_x1_in;
         b_x2_ff  <= b_x2_in;
         b_y1_ff  <= b_y1_in;
         b_y2_ff  <= b_y2_in;
      end
      if (c_en) begin
         c_ff <= c_in;
      end
   end

   assign out_valid = c_v_ff;
   assign out_data  = c_ff;

endmodule

// ----- src/plsm_div.sv -----
// Multiply stage and pipelined restoring divider, two quotient bits per stage.
// Depends on plsm_pkg.
module plsm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  plsm_pkg::interp_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output plsm_pkg::quot_type   out_data
);
   import plsm_pkg::*;

   localparam int NS = DIV_STEPS + 1;

   logic [PROD_W-1:0]  prod;
   logic               en       [NS];
   logic               v_ff     [NS];
   side_type           side_ff  [NS];
   side_type           side_in  [NS];
   logic [SPEED_W-1:0] span_ff  [NS];
   logic [SPEED_W-1:0] span_in  [NS];
   logic [SPEED_W-1:0] rem_ff   [NS];
   logic [SPEED_W-1:0] rem_in   [NS];
   logic [SPEED_W-1:0] low_ff   [NS];
   logic [SPEED_W-1:0] low_in   [NS];
   logic [QUO_W-1:0]   quo_ff   [NS];
   logic [QUO_W-1:0]   quo_in   [NS];

   assign prod = PROD_W'(in_data.dy_mag) * PROD_W'(in_data.dx);

   always_comb begin : stall_chain
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[0];

   // dividend < span * 2^QUO_W, so the upper half already sits below span
   always_comb begin : next_calc
      logic [SPEED_W:0]   t;
      logic [SPEED_W-1:0] r;
      logic [SPEED_W-1:0] l;
      logic [QUO_W-1:0]   q;
      side_in[0] = in_data.side;
      span_in[0] = in_data.span;
      rem_in[0]  = prod[PROD_W-1:SPEED_W];
      low_in[0]  = prod[SPEED_W-1:0];
      quo_in[0]  = '0;
      for (int i = 1; i < NS; i++) begin
         r = rem_ff[i-1];
         l = low_ff[i-1];
         q = quo_ff[i-1];
         for (int b = 0; b < BITS_PER_STEP; b++) begin
            t = {r, l[SPEED_W-1]};
            l = {l[SPEED_W-2:0], 1'b0};
            if (t >= {1'b0, span_ff[i-1]}) begin
               t = t - {1'b0, span_ff[i-1]};
               q = {q[QUO_W-2:0], 1'b1};
            end else begin
               q = {q[QUO_W-2:0], 1'b0};
            end
            r = t[SPEED_W-1:0];
         end
         side_in[i] = side_ff[i-1];
         span_in[i] = span_ff[i-1];
         rem_in[i]  = r;
         low_in[i]  = l;
         quo_in[i]  = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) begin
            side_ff[i] <= side_in[i];
            span_ff[i] <= span_in[i];
            rem_ff[i]  <= rem_in[i];
            low_ff[i]  <= low_in[i];
            quo_ff[i]  <= quo_in[i];
         end
      end
   end

   assign out_valid     = v_ff[NS-1];
   assign out_data.side = side_ff[NS-1];
   assign out_data.quo  = quo_ff[NS-1];

endmodule

// ----- src/plsm_back.sv -----
// Back end: add the scaled step to the lower output, restore sign, saturate.
// Depends on plsm_pkg. Holds the output register.
module plsm_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  plsm_pkg::quot_type           in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [plsm_pkg::SPEED_W-1:0] out_speed,
   output logic [plsm_pkg::SEG_W-1:0]   out_seg
);
   import plsm_pkg::*;

   logic                    p_en, r_en;
   logic                    p_v_ff;
   logic                    p_neg_ff;
   logic [SEG_W-1:0]        p_seg_ff;
   logic signed [SUM_W-1:0] p_sum_ff, p_sum_in;
   logic [SUM_W-1:0]        step;

   logic                    r_v_ff;
   logic [SPEED_W-1:0]      r_speed_ff, r_speed_in;
   logic [SEG_W-1:0]        r_seg_ff;
   logic signed [SUM_W-1:0] res;

   assign r_en     = !r_v_ff || out_ready;
   assign p_en     = !p_v_ff || r_en;
   assign in_ready = p_en;

   // a zero-width segment gives its lower output
   assign step     = in_data.side.zero_span ? '0 : SUM_W'(in_data.quo);
   assign p_sum_in = $signed(SUM_W'(in_data.side.y1))
                     + (in_data.side.dy_neg ? -$signed(step) : $signed(step));

   always_comb begin
      res = p_neg_ff ? -p_sum_ff : p_sum_ff;
      if ((res[SUM_W-1:SPEED_W-1] == '0) || (res[SUM_W-1:SPEED_W-1] == '1)) begin
         r_speed_in = res[SPEED_W-1:0];
      end else if (res[SUM_W-1]) begin
         r_speed_in = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
         r_speed_in = {1'b0, {(SPEED_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
      end else begin
         if (p_en) begin
            p_v_ff <= in_valid;
         end
         if (r_en) begin
            r_v_ff <= p_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_en) begin
         p_neg_ff <= in_data.side.neg;
         p_seg_ff <= in_data.side.seg;
         p_sum_ff <= p_sum_in;
      end
      if (r_en) begin
         r_speed_ff <= r_speed_in;
         r_seg_ff   <= p_seg_ff;
      end
   end

   assign out_valid = r_v_ff;
   assign out_speed = r_speed_ff;
   assign out_seg   = r_seg_ff;

endmodule

// ----- bench/piecewise_linear_speed_map_test.sv -----
// Self-checking bench for the piecewise-linear speed map: directed curves, then
// random breakpoint sets and speeds under random idling and a long output stall.
// Depends on plsm_pkg and the piecewise_linear_speed_map top level only.
`timescale 1ns / 100ps

module piecewise_linear_speed_map_test;
   import plsm_pkg::*;

   localparam int LATENCY_WAIT = 16;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_ITEMS  = 80;
   localparam int HOLD_CYCLES  = 200;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WALK_ABS, REG_SLOW_RUN_ABS, REG_FAST_RUN_ABS, REG_SPRINT_ABS,
      REG_WALK_REL, REG_SLOW_RUN_REL, REG_FAST_RUN_REL, REG_SPRINT_REL
   } reg_index_type;

   typedef enum int {
      CURVE_SORTED_NARROW, CURVE_SORTED_WIDE, CURVE_UNSORTED, CURVE_EXTREMES
   } curve_kind_type;

   typedef struct {
      logic [SPEED_W-1:0] speed_out;
      logic [SEG_W-1:0]   segment;
   } speed_map_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SPEED_W-1:0]    req_tdata;   // [15:0] speed_in
   logic [0:0]            req_tuser;   // [0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [15:0] speed_out, [18:16] segment
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [SPEED_W-1:0]    csr_wdata;

   // bench copy of the breakpoint registers
   curve_type     abs_curve;
   curve_type     rel_curve;
   speed_map_type expected_maps[$];

   bit sender_gaps;
   bit receiver_gaps;
   bit hold_request;
   int mismatches   = 0;
   int quiet_cycles = 0;

   piecewise_linear_speed_map i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic speed_map_type predict_speed_map(op_type op, logic [SPEED_W-1:0] spd);
      curve_type     xs;
      curve_type     ys;
      logic          neg;
      longint        mag;
      longint        x1;
      longint        x2;
      longint        y1;
      longint        y2;
      longint        res;
      int            seg;
      speed_map_type m;
      xs  = (op == OP_REL_TO_ABS) ? rel_curve : abs_curve;
      ys  = (op == OP_REL_TO_ABS) ? abs_curve : rel_curve;
      neg = spd[SPEED_W-1];
      mag = longint'($signed(spd));
      if (neg) mag = -mag;
      seg = NUM_BP;
      for (int k = 0; k < NUM_BP; k++)
         if (seg == NUM_BP && mag <= longint'(xs[k])) seg = k;
      if (seg == NUM_BP) begin
         // past the last breakpoint: positive top value regardless of sign
         res = longint'(ys[NUM_BP-1]);
      end else begin
         x1 = (seg == 0) ? 0 : longint'(xs[seg-1]);
         y1 = (seg == 0) ? 0 : longint'(ys[seg-1]);
         x2 = longint'(xs[seg]);
         y2 = longint'(ys[seg]);
         if (x2 - x1 <= 0) res = y1;
         else res = y1 + ((y2 - y1) * (mag - x1)) / (x2 - x1);
         if (neg) res = -res;
      end
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      m.speed_out = res[SPEED_W-1:0];
      m.segment   = seg[SEG_W-1:0];
      return m;
   endfunction

   function automatic curve_type make_curve(bp_type b0, bp_type b1, bp_type b2, bp_type b3);
      curve_type c;
      c[0] = b0;
      c[1] = b1;
      c[2] = b2;
      c[3] = b3;
      return c;
   endfunction

   function automatic curve_type random_curve(curve_kind_type kind);
      curve_type c;
      bp_type    t;
      int        span;
      span = (kind == CURVE_SORTED_NARROW) ? 16'h0FFF : 16'hFFFF;
      for (int k = 0; k < NUM_BP; k++) begin
         c[k] = bp_type'($urandom_range(0, span));
         if (kind == CURVE_EXTREMES)
            c[k] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end
      if (kind == CURVE_SORTED_NARROW || kind == CURVE_SORTED_WIDE)
         for (int i = 0; i < NUM_BP - 1; i++)
            for (int k = 0; k < NUM_BP - 1 - i; k++)
               if (c[k] > c[k+1]) begin
                  t      = c[k];
                  c[k]   = c[k+1];
                  c[k+1] = t;
               end
      return c;
   endfunction

   function automatic logic [SPEED_W-1:0] signed_speed(longint mag, bit neg);
      longint v;
      v = neg ? -mag : mag;
      return v[SPEED_W-1:0];
   endfunction

   // half the picks fall around the breakpoints of the input-side curve
   function automatic logic [SPEED_W-1:0] pick_speed(curve_type xs);
      longint mag;
      case ($urandom_range(0, 3))
         0, 1: begin
            mag = longint'(xs[$urandom_range(0, NUM_BP-1)])
                  + longint'(int'($urandom_range(0, 4))) - 2;
            if (mag < 0) mag = 0;
            if (mag > 32768) mag = 32768;
         end
         2: return SPEED_W'($urandom_range(0, 16'hFFFF));
         default: mag = longint'($urandom_range(0, 300));
      endcase
      return signed_speed(mag, $urandom_range(0, 1) != 0);
   endfunction

   task automatic send_speed(op_type op, logic [SPEED_W-1:0] spd);
      @(negedge clock);
      while (sender_gaps && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= spd;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      expected_maps.push_back(predict_speed_map(op, spd));
   endtask

   task automatic send_both(logic [SPEED_W-1:0] spd);
      send_speed(OP_ABS_TO_REL, spd);
      send_speed(OP_REL_TO_ABS, spd);
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic load_curves(curve_type a, curve_type r);
      for (int i = 0; i < NUM_CSR; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= reg_index_type'(i);
         csr_wdata <= (i < NUM_BP) ? a[i] : r[i - NUM_BP];
         @(posedge clock);
      end
      @(negedge clock);
      csr_we    <= 1'b0;
      abs_curve = a;
      rel_curve = r;
   endtask

   // registers still at their reset value: every curve point is zero
   task automatic test_reset_curve();
      send_both(16'h0000);
      send_speed(OP_ABS_TO_REL, 16'h8000);
      send_speed(OP_REL_TO_ABS, 16'h7FFF);
      finish_phase();
   endtask

   task automatic test_nominal_curve();
      load_curves(make_curve(16'h0100, 16'h0300, 16'h0800, 16'h1000),
                  make_curve(16'h0080, 16'h0200, 16'h0600, 16'h7F00));
      send_speed(OP_ABS_TO_REL, 16'h0100);   // on a breakpoint: inclusive
      send_speed(OP_ABS_TO_REL, 16'h0101);
      send_speed(OP_ABS_TO_REL, 16'h0500);
      send_speed(OP_ABS_TO_REL, signed_speed(16'h0500, 1));
      send_speed(OP_ABS_TO_REL, 16'h1001);   // beyond top
      send_speed(OP_ABS_TO_REL, 16'h8000);   // most negative, beyond top
      send_speed(OP_REL_TO_ABS, 16'h0300);
      send_speed(OP_REL_TO_ABS, signed_speed(16'h7000, 1));
      send_speed(OP_REL_TO_ABS, 16'h7FFF);
      finish_phase();
   endtask

   // input breakpoints out of order, output breakpoints rising then falling
   task automatic test_falling_unsorted_curve();
      load_curves(make_curve(16'h0400, 16'h0100, 16'h0800, 16'h0200),
                  make_curve(16'h0400, 16'h0600, 16'h0200, 16'h0000));
      send_speed(OP_ABS_TO_REL, 16'h0600);
      send_speed(OP_ABS_TO_REL, signed_speed(16'h0600, 1));
      send_speed(OP_ABS_TO_REL, 16'h0300);
      send_speed(OP_ABS_TO_REL, signed_speed(16'h0A00, 1));
      send_speed(OP_REL_TO_ABS, 16'h0500);
      finish_phase();
   endtask

   task automatic test_saturation();
      load_curves(make_curve(16'h8000, 16'h9000, 16'hA000, 16'hFFFF),
                  make_curve(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
      send_speed(OP_ABS_TO_REL, 16'h8000);
      send_speed(OP_ABS_TO_REL, 16'h4000);
      send_speed(OP_ABS_TO_REL, 16'h7FFF);
      send_speed(OP_REL_TO_ABS, 16'h8000);
      finish_phase();
   endtask

   task automatic run_random_items(curve_kind_type kind);
      op_type op;
      load_curves(random_curve(kind), random_curve(kind));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         op = op_type'($urandom_range(0, 1));
         send_speed(op, pick_speed((op == OP_REL_TO_ABS) ? rel_curve : abs_curve));
      end
      finish_phase();
   endtask

   task automatic test_random_mapping();
      run_random_items(CURVE_SORTED_NARROW);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      run_random_items(CURVE_SORTED_WIDE);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      run_random_items(CURVE_UNSORTED);
      run_random_items(CURVE_EXTREMES);
   endtask

   // output held off long enough for the pipeline to fill and stall the input
   task automatic test_backpressure();
      hold_request = 1'b1;
      run_random_items(CURVE_SORTED_NARROW);
   endtask

   // receiver: random idling, and one long hold-off counted here
   initial begin : receiver
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= !(receiver_gaps && $urandom_range(0, 99) < 25);
         end
      end
   end

   always @(posedge clock) begin
      speed_map_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_maps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = expected_maps.pop_front();
            if (rsp_tdata[SPEED_W-1:0] !== want.speed_out ||
                rsp_tdata[SPEED_W+SEG_W-1:SPEED_W] !== want.segment) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: speed_out exp %h got %h, segment exp %0d got %0d",
                           want.speed_out, rsp_tdata[SPEED_W-1:0], want.segment,
                           rsp_tdata[SPEED_W+SEG_W-1:SPEED_W]);
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("piecewise_linear_speed_map test failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      abs_curve     = '0;
      rel_curve     = '0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      hold_request  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_curve();
      test_nominal_curve();
      test_falling_unsorted_curve();
      test_saturation();
      test_random_mapping();
      test_backpressure();

      if (mismatches == 0 && expected_maps.size() == 0)
         $display("piecewise_linear_speed_map test passed");
      else
         $display("piecewise_linear_speed_map test failed");
      $finish;
   end

endmodule
